@@ sv/dsrt_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dsrt_pkg: shared types and constants of the date sorted record table
// Field widths, operation and status codes, the per-cell move command and
// the query word that every cell sees.
// ---------------------------------------------------------------------------
package dsrt_pkg;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int CODE_W   = 48;
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int DATE_W   = YEAR_W + MONTH_W + DAY_W;
	localparam int POSTAL_W = 17;
	localparam int HANDLE_W = 16;

	typedef logic [DATE_W-1:0] date_t;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_FIND    = 2'd1,
		OP_EXTRACT = 2'd2,
		OP_RANGE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MV_HOLD  = 2'd0,
		MV_NEW   = 2'd1,
		MV_LEFT  = 2'd2,
		MV_RIGHT = 2'd3
	} move_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_BUSY = 1'b1
	} state_t;

	// broadcast to all cells; key is already masked to the KEY_W key width
	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] key;
		date_t             lo;
		date_t             hi;
	} query_t;

	typedef struct packed {
		logic after;   // slot is at or past the insert point
		logic match;   // record satisfies the lookup
	} cell_flag_t;

endpackage
`default_nettype wire

@@ sv/dsrt_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dsrt_if: request and response channels of the record table
// Valid/ready channels; a word moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface dsrt_in_if import dsrt_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [CODE_W-1:0]   key_code;
	logic [YEAR_W-1:0]   date_year;
	logic [MONTH_W-1:0]  date_month;
	logic [DAY_W-1:0]    date_day;
	logic [POSTAL_W-1:0] postal_code;
	logic [HANDLE_W-1:0] record_handle;
	logic [YEAR_W-1:0]   upper_year;
	logic [MONTH_W-1:0]  upper_month;
	logic [DAY_W-1:0]    upper_day;

	modport source (
		output valid, op, key_code, date_year, date_month, date_day,
		       postal_code, record_handle, upper_year, upper_month, upper_day,
		input  ready
	);
	modport sink (
		input  valid, op, key_code, date_year, date_month, date_day,
		       postal_code, record_handle, upper_year, upper_month, upper_day,
		output ready
	);
endinterface

interface dsrt_out_if import dsrt_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CODE_W-1:0]   out_code;
	logic [YEAR_W-1:0]   out_year;
	logic [MONTH_W-1:0]  out_month;
	logic [DAY_W-1:0]    out_day;
	logic [POSTAL_W-1:0] out_postal;
	logic [HANDLE_W-1:0] out_handle;

	modport source (
		output valid, status, out_code, out_year, out_month, out_day,
		       out_postal, out_handle,
		input  ready
	);
	modport sink (
		input  valid, status, out_code, out_year, out_month, out_day,
		       out_postal, out_handle,
		output ready
	);
endinterface
`default_nettype wire

@@ sv/date_sorted_record_table.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// date_sorted_record_table: bounded table of records in birth-date order
// A chain of CAPACITY cells holds the records sorted; all cells compare the
// query at once, then shift toward or away from the selected slot.
// ---------------------------------------------------------------------------
// Each request is taken in an accept cycle (request registered), then in an
//   update cycle every cell compares, the chain shifts and the result is
//   registered; no new request is taken until that update is done.
// A stalled result holds the update cycle; the next request is taken while a
//   result waits. Reset empties the table (count to zero); no clearing pass.

module date_sorted_record_table import dsrt_pkg::*; #(
	parameter int CAPACITY    = 64,
	parameter int CODE_CHARS  = 6,
	parameter int HANDLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	dsrt_in_if.sink     request,
	dsrt_out_if.source  response
);

	localparam int KEY_W    = (CODE_CHARS * 8 < CODE_W) ? CODE_CHARS * 8 : CODE_W;
	localparam int HS_W     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int REC_W    = KEY_W + DATE_W + POSTAL_W + HS_W;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATE_OFS = HS_W + POSTAL_W;
	localparam int KEY_OFS  = DATE_OFS + DATE_W;

	state_t              state_q, state_d;
	query_t              query_q;
	logic [POSTAL_W-1:0] postal_q;
	logic [HS_W-1:0]     handle_q;
	logic [CNT_W-1:0]    count_q;

	logic                out_valid_q;
	status_t             status_q;
	logic [CODE_W-1:0]   code_q;
	date_t               date_q;
	logic [POSTAL_W-1:0] opostal_q;
	logic [HANDLE_W-1:0] ohandle_q;

	logic accept, commit, full, found, in_ready;
	logic [CODE_W-1:0] key_masked;

	logic [REC_W-1:0]    new_rec;
	logic [REC_W-1:0]    rec  [CAPACITY];
	cell_flag_t          flag [CAPACITY];
	move_t               move [CAPACITY];
	logic [CAPACITY-1:0] occ, after_v, after_prev, match_v, pre, pre_excl, hit;
	logic [CAPACITY-1:0] col  [REC_W];
	logic [REC_W-1:0]    sel_rec;
	logic [CODE_W-1:0]   sel_code;
	logic [HANDLE_W-1:0] sel_handle;

	// ---------------- control ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = S_BUSY;
			S_BUSY:  if (commit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		commit   = (state_q == S_BUSY) && (!out_valid_q || response.ready);
	end

	assign request.ready = in_ready;
	assign accept        = request.valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		key_masked = '0;
		key_masked[KEY_W-1:0] = request.key_code[KEY_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			query_q.op  <= op_t'(request.op);
			query_q.key <= key_masked;
			query_q.lo  <= {request.date_year, request.date_month, request.date_day};
			query_q.hi  <= {request.upper_year, request.upper_month, request.upper_day};
			postal_q    <= request.postal_code;
			handle_q    <= request.record_handle[HS_W-1:0];
		end
	end

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign new_rec = {query_q.key[KEY_W-1:0], query_q.lo, postal_q, handle_q};

	// ---------------- cell chain ----------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [REC_W-1:0] left_in, right_in;

		if (i == 0) begin : g_first
			assign left_in = new_rec;
		end else begin : g_mid_l
			assign left_in = rec[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_in = new_rec;
		end else begin : g_mid_r
			assign right_in = rec[i+1];
		end

		assign occ[i]     = (CNT_W'(i) < count_q);
		assign after_v[i] = flag[i].after;
		assign match_v[i] = flag[i].match;

		dsrt_cell #(
			.KEY_W (KEY_W),
			.HS_W  (HS_W)
		) u_cell (
			.clk       (clk),
			.query     (query_q),
			.occ       (occ[i]),
			.move      (move[i]),
			.new_rec   (new_rec),
			.left_rec  (left_in),
			.right_rec (right_in),
			.rec       (rec[i]),
			.flag      (flag[i])
		);
	end

	dsrt_prefix #(
		.N (CAPACITY)
	) u_prefix (
		.flags  (match_v),
		.prefix (pre)
	);

	assign after_prev = {after_v[CAPACITY-2:0], 1'b0};
	assign pre_excl   = {pre[CAPACITY-2:0], 1'b0};
	assign hit        = match_v & ~pre_excl;
	assign found      = pre[CAPACITY-1];

	// insert: slots past the insert point take their left neighbor;
	// extract and range: slots from the hit onward take their right neighbor
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			move[i] = MV_HOLD;
			if (commit) begin
				case (query_q.op)
					OP_INSERT: begin
						if (!full) begin
							if (after_prev[i])
								move[i] = MV_LEFT;
							else if (after_v[i])
								move[i] = MV_NEW;
						end
					end
					OP_EXTRACT, OP_RANGE: begin
						if (pre[i] && (i < CAPACITY - 1))
							move[i] = MV_RIGHT;
					end
					default: move[i] = MV_HOLD;
				endcase
			end
		end
	end

	// one-hot read of the first matching cell, bit by bit
	for (genvar b = 0; b < REC_W; b++) begin : g_col
		for (genvar i = 0; i < CAPACITY; i++) begin : g_row
			assign col[b][i] = rec[i][b];
		end
		assign sel_rec[b] = |(hit & col[b]);
	end

	always_comb begin
		sel_code   = '0;
		sel_handle = '0;
		sel_code[KEY_W-1:0]  = sel_rec[KEY_OFS +: KEY_W];
		sel_handle[HS_W-1:0] = sel_rec[HS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			if (query_q.op == OP_INSERT && !full)
				count_q <= count_q + CNT_W'(1);
			else if ((query_q.op == OP_EXTRACT || query_q.op == OP_RANGE) && found)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			code_q    <= '0;
			date_q    <= '0;
			opostal_q <= '0;
			ohandle_q <= '0;
			if (query_q.op == OP_INSERT) begin
				status_q <= full ? ST_FULL : ST_OK;
			end else if (found) begin
				status_q  <= ST_OK;
				code_q    <= sel_code;
				date_q    <= sel_rec[DATE_OFS +: DATE_W];
				opostal_q <= sel_rec[HS_W +: POSTAL_W];
				ohandle_q <= sel_handle;
			end else begin
				status_q <= ST_NONE;
			end
		end
	end

	assign response.valid      = out_valid_q;
	assign response.status     = status_q;
	assign response.out_code   = code_q;
	assign response.out_year   = date_q[DATE_W-1 -: YEAR_W];
	assign response.out_month  = date_q[DAY_W +: MONTH_W];
	assign response.out_day    = date_q[DAY_W-1:0];
	assign response.out_postal = opostal_q;
	assign response.out_handle = ohandle_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("record count above capacity");

	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> $onehot0(hit))
		else $error("more than one cell selected");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && query_q.op == OP_INSERT && full) |=> $stable(count_q))
		else $error("refused insert changed the count");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_BUSY))
		else $error("result word without an update cycle");

endmodule
`default_nettype wire

@@ sv/dsrt_prefix.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dsrt_prefix: inclusive prefix OR over the cell match flags
// Log-depth parallel prefix; bit i is set when any cell 0..i is set.
// ---------------------------------------------------------------------------
module dsrt_prefix #(
	parameter int N = 64
) (
	input  logic [N-1:0] flags,
	output logic [N-1:0] prefix
);

	localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0] lvl [LEVELS+1];

	assign lvl[0] = flags;

	for (genvar l = 0; l < LEVELS; l++) begin : g_level
		for (genvar i = 0; i < N; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1 << l)];
			end else begin : g_pass
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign prefix = lvl[LEVELS];

endmodule
`default_nettype wire

@@ sv/dsrt_cell.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// dsrt_cell: one slot of the sorted record chain
// Holds one record, compares it against the broadcast query and loads from
// the new record or a neighbor as commanded.
// ---------------------------------------------------------------------------
module dsrt_cell import dsrt_pkg::*; #(
	parameter int KEY_W = 48,
	parameter int HS_W  = 16
) (
	input  logic                                  clk,
	input  query_t                                query,
	input  logic                                  occ,
	input  move_t                                 move,
	input  logic [KEY_W+DATE_W+POSTAL_W+HS_W-1:0] new_rec,
	input  logic [KEY_W+DATE_W+POSTAL_W+HS_W-1:0] left_rec,
	input  logic [KEY_W+DATE_W+POSTAL_W+HS_W-1:0] right_rec,
	output logic [KEY_W+DATE_W+POSTAL_W+HS_W-1:0] rec,
	output cell_flag_t                            flag
);

	localparam int REC_W    = KEY_W + DATE_W + POSTAL_W + HS_W;
	localparam int DATE_OFS = HS_W + POSTAL_W;
	localparam int KEY_OFS  = DATE_OFS + DATE_W;

	logic [REC_W-1:0] rec_q;
	date_t            date;
	logic [KEY_W-1:0] key;

	assign rec  = rec_q;
	assign date = rec_q[DATE_OFS +: DATE_W];
	assign key  = rec_q[KEY_OFS +: KEY_W];

	always_comb begin
		flag.after = !occ || (date > query.lo);
		case (query.op)
			OP_FIND, OP_EXTRACT: flag.match = occ && (key == query.key[KEY_W-1:0]);
			OP_RANGE:            flag.match = occ && (date >= query.lo) && (date <= query.hi);
			default:             flag.match = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (move)
			MV_NEW:   rec_q <= new_rec;
			MV_LEFT:  rec_q <= left_rec;
			MV_RIGHT: rec_q <= right_rec;
			default:  rec_q <= rec_q;
		endcase
	end

endmodule
`default_nettype wire

@@ bench/tb_date_sorted_record_table.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tb_date_sorted_record_table: self-checking bench for the record table
// Drives insert, find, extract and range-extract words with random gaps,
// keeps a sorted shadow roster to predict every reply, and checks each
// reply field by field. Includes a long response hold-off that stalls the block.
// ---------------------------------------------------------------------------
module tb_date_sorted_record_table import dsrt_pkg::*; ;

	localparam int CAPACITY    = 64;
	localparam int CODE_CHARS  = 6;
	localparam int HANDLE_BITS = 16;
	localparam int IDLE_PCT    = 7;
	localparam int HOLD_CYCLES = 60;
	localparam int STALL_LIMIT = 4000;

	localparam int KEY_BITS = (CODE_CHARS * 8 < CODE_W) ? CODE_CHARS * 8 : CODE_W;
	localparam int REF_BITS = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam logic [CODE_W-1:0]   KEY_MASK = {CODE_W{1'b1}} >> (CODE_W - KEY_BITS);
	localparam logic [HANDLE_W-1:0] REF_MASK = {HANDLE_W{1'b1}} >> (HANDLE_W - REF_BITS);

	typedef struct packed {
		op_t                 op;
		logic [CODE_W-1:0]   code;
		date_t               lo;
		date_t               hi;
		logic [POSTAL_W-1:0] postal;
		logic [HANDLE_W-1:0] handle;
	} request_t;

	typedef struct packed {
		logic [CODE_W-1:0]   code;
		date_t               date;
		logic [POSTAL_W-1:0] postal;
		logic [HANDLE_W-1:0] handle;
	} record_t;

	typedef struct packed {
		status_t             status;
		logic [CODE_W-1:0]   code;
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [POSTAL_W-1:0] postal;
		logic [HANDLE_W-1:0] handle;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	dsrt_in_if  req_bus ();
	dsrt_out_if rsp_bus ();

	date_sorted_record_table #(
		.CAPACITY    (CAPACITY),
		.CODE_CHARS  (CODE_CHARS),
		.HANDLE_BITS (HANDLE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_bus),
		.response (rsp_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	request_t          ops_to_send[$];
	reply_t            replies_due[$];
	record_t           roster[$];
	logic [CODE_W-1:0] known_codes[$];

	request_t offered;
	reply_t   want;
	int       words_sent   = 0;
	int       replies_seen = 0;
	int       errors       = 0;
	int       inserts      = 0;
	int       refused      = 0;
	int       hits         = 0;
	int       misses       = 0;
	int       peak         = 0;
	int       hold_left    = 0;
	int       hold_at      = 0;
	bit       hold_done    = 1'b0;
	int       silent_cycles = 0;

	// shadow of the table: updates the sorted roster, queues the reply due
	function automatic void apply_to_roster(input request_t r);
		reply_t            rep;
		record_t           rec;
		int                slot;
		logic [CODE_W-1:0] key;
		rep  = '0;
		key  = r.code & KEY_MASK;
		slot = -1;
		case (r.op)
			OP_INSERT: begin
				inserts++;
				if (roster.size() >= CAPACITY) begin
					rep.status = ST_FULL;
					refused++;
				end else begin
					slot = 0;
					// equal dates: new record goes after the existing ones
					while (slot < roster.size() && roster[slot].date <= r.lo)
						slot++;
					rec.code   = key;
					rec.date   = r.lo;
					rec.postal = r.postal;
					rec.handle = r.handle & REF_MASK;
					roster.insert(slot, rec);
					if (roster.size() > peak)
						peak = roster.size();
				end
			end
			OP_FIND, OP_EXTRACT: begin
				for (int i = 0; i < roster.size(); i++)
					if (slot < 0 && (roster[i].code & KEY_MASK) == key)
						slot = i;
			end
			default: begin
				for (int i = 0; i < roster.size(); i++)
					if (slot < 0 && roster[i].date >= r.lo && roster[i].date <= r.hi)
						slot = i;
			end
		endcase
		if (r.op != OP_INSERT) begin
			if (slot < 0) begin
				rep.status = ST_NONE;
				misses++;
			end else begin
				rep.status = ST_OK;
				rep.code   = roster[slot].code;
				{rep.year, rep.month, rep.day} = roster[slot].date;
				rep.postal = roster[slot].postal;
				rep.handle = roster[slot].handle;
				if (r.op != OP_FIND)
					roster.delete(slot);
				hits++;
			end
		end
		replies_due.push_back(rep);
	endfunction

	function automatic void queue_op(input op_t op, input logic [CODE_W-1:0] code,
			input date_t lo, input date_t hi, input logic [POSTAL_W-1:0] postal,
			input logic [HANDLE_W-1:0] handle);
		request_t r;
		r.op     = op;
		r.code   = code;
		r.lo     = lo;
		r.hi     = hi;
		r.postal = postal;
		r.handle = handle;
		ops_to_send.push_back(r);
	endfunction

	// mostly a narrow window so equal dates are common; sometimes any bits
	function automatic date_t pick_date();
		if ($urandom_range(0, 9) == 0)
			return date_t'($urandom);
		return {YEAR_W'(1990 + $urandom_range(0, 3)), MONTH_W'($urandom_range(1, 4)),
			DAY_W'($urandom_range(1, 8))};
	endfunction

	function automatic logic [CODE_W-1:0] pick_code(input int reuse_pct);
		if (known_codes.size() != 0 && $urandom_range(0, 99) < reuse_pct)
			return known_codes[$urandom_range(0, known_codes.size() - 1)];
		return {16'($urandom), $urandom};
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_val,
			input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, name, exp_val, act_val);
			errors++;
		end
	endtask

	// driver: holds a word until taken, then pulls the next from the queue
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				apply_to_roster(offered);
				words_sent++;
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (ops_to_send.size() != 0 && ((words_sent >= 500 && words_sent < 800) ||
						$urandom_range(0, 99) >= IDLE_PCT)) begin
					offered = ops_to_send.pop_front();
					req_bus.valid         <= 1'b1;
					req_bus.op            <= offered.op;
					req_bus.key_code      <= offered.code;
					{req_bus.date_year, req_bus.date_month, req_bus.date_day} <= offered.lo;
					{req_bus.upper_year, req_bus.upper_month, req_bus.upper_day} <= offered.hi;
					req_bus.postal_code   <= offered.postal;
					req_bus.record_handle <= offered.handle;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each reply word against the oldest one due
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				replies_seen++;
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected reply, expected none, actual status %0d code %0h",
						$time, rsp_bus.status, rsp_bus.out_code);
					errors++;
				end else begin
					want = replies_due.pop_front();
					check_field("status", want.status, rsp_bus.status);
					check_field("out_code", want.code, rsp_bus.out_code);
					check_field("out_year", want.year, rsp_bus.out_year);
					check_field("out_month", want.month, rsp_bus.out_month);
					check_field("out_day", want.day, rsp_bus.out_day);
					check_field("out_postal", want.postal, rsp_bus.out_postal);
					check_field("out_handle", want.handle, rsp_bus.out_handle);
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (!hold_done && replies_seen >= 400) begin
				// long back-pressure: the table must stall its request side
				hold_done = 1'b1;
				hold_at   = replies_seen;
				hold_left = HOLD_CYCLES - 1;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= (replies_seen >= 500 && replies_seen < 800) ||
					$urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			silent_cycles <= 0;
		end else if (silent_cycles == STALL_LIMIT) begin
			$display("%0t: timeout, no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			silent_cycles <= silent_cycles + 1;
		end
	end

	initial begin
		logic [CODE_W-1:0] code_a;
		logic [CODE_W-1:0] code_b;
		logic [CODE_W-1:0] code_c;
		logic [CODE_W-1:0] code;
		date_t             mid_date;
		date_t             early_date;
		date_t             late_date;
		date_t             a;
		date_t             b;
		int                insert_pct;
		op_t               op;

		req_bus.valid         = 1'b0;
		req_bus.op            = '0;
		req_bus.key_code      = '0;
		req_bus.date_year     = '0;
		req_bus.date_month    = '0;
		req_bus.date_day      = '0;
		req_bus.postal_code   = '0;
		req_bus.record_handle = '0;
		req_bus.upper_year    = '0;
		req_bus.upper_month   = '0;
		req_bus.upper_day     = '0;
		rsp_bus.ready         = 1'b0;
		arst_n                = 1'b0;

		// codes with a byte past a zero byte must still compare in full
		code_a     = 48'h41_00_42_00_00_00;
		code_b     = 48'h41_00_00_00_00_00;
		code_c     = 48'h41_00_43_00_00_00;
		mid_date   = {YEAR_W'(2000), MONTH_W'(6), DAY_W'(15)};
		early_date = {YEAR_W'(1999), MONTH_W'(1), DAY_W'(1)};
		late_date  = {YEAR_W'(2001), MONTH_W'(1), DAY_W'(1)};

		queue_op(OP_FIND, code_a, '0, '0, '0, '0);
		queue_op(OP_EXTRACT, code_a, '0, '0, '0, '0);
		queue_op(OP_RANGE, '0, '0, '1, '0, '0);
		queue_op(OP_INSERT, '1, '1, '0, '1, '1);
		queue_op(OP_INSERT, '0, '0, '1, '0, '0);
		queue_op(OP_INSERT, code_a, mid_date, '0, POSTAL_W'(12345), HANDLE_W'(1));
		queue_op(OP_INSERT, code_b, mid_date, '0, POSTAL_W'(99999), HANDLE_W'(2));
		queue_op(OP_INSERT, code_a, early_date, '0, POSTAL_W'(5), HANDLE_W'(3));
		queue_op(OP_FIND, code_a, '0, '0, '0, '0);
		queue_op(OP_FIND, code_b, '0, '0, '0, '0);
		queue_op(OP_FIND, code_c, '0, '0, '0, '0);
		queue_op(OP_EXTRACT, code_a, '0, '0, '0, '0);
		queue_op(OP_FIND, code_a, '0, '0, '0, '0);
		queue_op(OP_RANGE, '0, mid_date, mid_date, '0, '0);
		queue_op(OP_RANGE, '0, late_date, mid_date, '0, '0);
		queue_op(OP_RANGE, '0, '0, '0, '0, '0);
		queue_op(OP_RANGE, '0, '1, '1, '0, '0);
		queue_op(OP_EXTRACT, '1, '0, '0, '0, '0);
		queue_op(OP_INSERT, '1, mid_date, '0, '1, '0);
		queue_op(OP_EXTRACT, '1, '0, '0, '0, '0);
		queue_op(OP_RANGE, '0, '0, '1, '0, '0);
		queue_op(OP_FIND, code_b, '0, '0, '0, '0);

		// segments pick fill-heavy, mixed or drain-heavy at random; the first two fill up
		for (int seg = 0; seg < 26; seg++) begin
			if (seg == 0)
				insert_pct = 100;
			else if (seg == 1)
				insert_pct = 85;
			else begin
				case ($urandom_range(0, 2))
					0:       insert_pct = 85;
					1:       insert_pct = 50;
					default: insert_pct = 15;
				endcase
			end
			for (int k = 0; k < 50; k++) begin
				if ($urandom_range(0, 99) < insert_pct) begin
					code = pick_code(25);
					queue_op(OP_INSERT, code, pick_date(), date_t'($urandom),
						POSTAL_W'($urandom), HANDLE_W'($urandom));
					known_codes.push_back(code);
					if (known_codes.size() > 80)
						void'(known_codes.pop_front());
				end else begin
					op = op_t'($urandom_range(1, 3));
					if (op == OP_RANGE) begin
						a = pick_date();
						b = pick_date();
						case ($urandom_range(0, 9))
							0: begin
								a = '0;
								b = '1;
							end
							1: ;  // may come out inverted
							2, 3, 4, 5: b = a + date_t'($urandom_range(0, 64));
							default: if (a > b) {a, b} = {b, a};
						endcase
						queue_op(op, {16'($urandom), $urandom}, a, b,
							POSTAL_W'($urandom), HANDLE_W'($urandom));
					end else begin
						queue_op(op, pick_code(70), date_t'($urandom), date_t'($urandom),
							POSTAL_W'($urandom), HANDLE_W'($urandom));
					end
				end
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (ops_to_send.size() != 0 || req_bus.valid)
			@(negedge clk);
		while (replies_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("%0d requests, %0d inserts (%0d refused as full), %0d hits, %0d misses",
			words_sent, inserts, refused, hits, misses);
		$display("peak fill %0d of %0d, %0d-cycle response hold at reply %0d, %0d mismatches",
			peak, CAPACITY, HOLD_CYCLES, hold_at, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
